FILE: hdl/xsrd_pkg.sv
// ----------------------------------------------------------------------------
// xsrd_pkg
// Types and constants shared by the cross-reference stream row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xsrd_pkg;

  // One stream byte as it arrives from the inflate side
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_item_t;

  // One decoded cross-reference entry
  typedef struct packed {
    logic [23:0] object_number;
    logic [1:0]  entry_kind;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic        filter_error;
  } out_item_t;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned FieldWW  = 3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_TYPE_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_WIDTH = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_THIRD_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PREDICTOR_ON = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_OBJECT = 3'd4;

  // Register reset values
  localparam logic [FieldWW-1:0] TYPE_WIDTH_RST   = 3'd1;
  localparam logic [FieldWW-1:0] SECOND_WIDTH_RST = 3'd4;
  localparam logic [FieldWW-1:0] THIRD_WIDTH_RST  = 3'd2;
  localparam logic               PREDICTOR_RST    = 1'b1;
  localparam logic [23:0]        FIRST_OBJECT_RST = 24'd0;

  // PNG Up filter tag, object number ceiling, entry kinds
  localparam logic [7:0]  UP_TAG       = 8'd2;
  localparam logic [23:0] OBJ_MAX      = 24'hFFFFFF;
  localparam logic [1:0]  KIND_FREE    = 2'd0;
  localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
  localparam logic [31:0] KIND_MAX_VAL = 32'd2;

endpackage

`default_nettype wire

FILE: hdl/xsrd_out_skid.sv
// ----------------------------------------------------------------------------
// xsrd_out_skid
// Output register plus one skid entry, so a result can be loaded while the
// receiver stalls. full_o is registered and back-pressures the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module xsrd_out_skid (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire xsrd_pkg::out_item_t  push_item_i,
  output logic                      full_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output xsrd_pkg::out_item_t       out_item_o
);
  import xsrd_pkg::*;

  logic      out_valid_q, skid_valid_q;
  out_item_t out_item_q, skid_item_q;
  logic      out_load;

  // output register may take a new item when empty or draining
  assign out_load = !out_valid_q || !out_stall_i;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= skid_valid_q ? skid_item_q : push_item_i;
    end else if (push_i) begin
      skid_item_q <= push_item_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while output is empty");

  // push against a stalled output lands in the skid entry
  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && out_valid_q && out_stall_i |=> skid_valid_q)
    else $error("result lost under stall");

  // a draining output takes the skid item
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && skid_valid_q |=> out_valid_q && !skid_valid_q)
    else $error("skid item not moved to output");
`endif

endmodule

`default_nettype wire

FILE: hdl/xref_stream_row_decoder.sv
// ----------------------------------------------------------------------------
// xref_stream_row_decoder
// Splits inflated cross-reference stream bytes into rows, undoes the PNG Up
// predictor and emits one decoded entry per row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one stream byte
//   per item; stream_start marks the first byte of a new stream and clears
//   the row count and the previous row.
//   Output channel (out_valid_o / out_stall_i / out_item_o) gives one entry
//   on the last byte of each row.
//   Configuration (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) is
//   always ready; a write restarts the current row and forgets the previous
//   row. Index 0 type width, 1 second width, 2 third width, 3 predictor on,
//   4 first object number. Other indexes are ignored.
// Timing:
//   One byte accepted per cycle while in_stall_o is low. A row's entry is
//   registered in the output register, or in the skid entry under stall.
//   The row state update (byte add with previous row, field shift) is a registered loop.
// Reset:
//   Widths 1/4/2, predictor on, first object 0, row state cleared.
// Stall:
//   An output register plus one skid entry absorb results; in_stall_o rises
//   only when the skid entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module xref_stream_row_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire xsrd_pkg::in_item_t                 in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output xsrd_pkg::out_item_t                     out_item_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [xsrd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [xsrd_pkg::CfgDataW-1:0]      cfg_data_i
);
  import xsrd_pkg::*;

  localparam int unsigned PrevDepth = 3 * MAX_FIELD_BYTES;
  localparam int unsigned IdxW      = (PrevDepth > 1) ? $clog2(PrevDepth) : 1;
  localparam int unsigned PosW      = $clog2(PrevDepth + 2);

  // configuration registers
  logic [FieldWW-1:0] type_w_q, second_w_q, third_w_q;
  logic               pred_q;
  logic [23:0]        first_obj_q;

  // row state
  logic [7:0]      prev_q [PrevDepth];
  logic            prev_valid_q;
  logic [PosW-1:0] pos_q;
  logic [7:0]      row_tag_q;
  logic [31:0]     type_acc_q, first_acc_q, second_acc_q;
  logic [23:0]     row_count_q;

  logic      cfg_we, cfg_hit, accept, push, skid_full;
  out_item_t result;

  function automatic logic [PosW-1:0] clamp_w(logic [FieldWW-1:0] w);
    if (32'(w) > MAX_FIELD_BYTES) return PosW'(MAX_FIELD_BYTES);
    return PosW'(w);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = skid_full;
  assign accept      = in_valid_i && !in_stall_o;

  // register index decode
  always_comb begin
    case (cfg_index_i)
      CFG_TYPE_WIDTH, CFG_SECOND_WIDTH, CFG_THIRD_WIDTH,
      CFG_PREDICTOR_ON, CFG_FIRST_OBJECT: cfg_hit = 1'b1;
      default:                            cfg_hit = 1'b0;
    endcase
  end

  // row geometry
  logic [PosW-1:0] tw, sw, hw, tag_len, len;
  assign tw      = clamp_w(type_w_q);
  assign sw      = clamp_w(second_w_q);
  assign hw      = clamp_w(third_w_q);
  assign tag_len = PosW'(pred_q);
  assign len     = tag_len + tw + sw + hw;

  // state as seen by this byte, after an optional stream start
  logic            start;
  logic [PosW-1:0] pos_e, pos, pos_inc, d;
  logic            prev_valid_e;
  logic [7:0]      row_tag_e;
  logic [31:0]     type_e, first_e, second_e;
  logic [23:0]     row_count_e;

  assign start        = in_item_i.stream_start;
  assign pos_e        = start ? '0 : pos_q;
  assign prev_valid_e = start ? 1'b0 : prev_valid_q;
  assign row_tag_e    = start ? '0 : row_tag_q;
  assign type_e       = start ? '0 : type_acc_q;
  assign first_e      = start ? '0 : first_acc_q;
  assign second_e     = start ? '0 : second_acc_q;
  assign row_count_e  = start ? '0 : row_count_q;

  assign pos     = (pos_e >= len) ? '0 : pos_e;
  assign pos_inc = pos + PosW'(1);
  assign d       = pos - tag_len;

  // byte decode: Up predictor, then shift into the current field
  logic            is_tag, last, err, prev_we;
  logic [IdxW-1:0] idx;
  logic [7:0]      v, row_tag_n;
  logic [31:0]     type_n, first_n, second_n;
  logic [24:0]     obj_sum;

  assign is_tag    = pred_q && (pos == '0);
  assign idx       = d[IdxW-1:0];
  assign v         = (pred_q && prev_valid_e) ? in_item_i.data_byte + prev_q[idx]
                                              : in_item_i.data_byte;
  assign row_tag_n = is_tag ? in_item_i.data_byte : row_tag_e;
  assign prev_we   = accept && !(cfg_we && cfg_hit) && (len != '0) && pred_q && !is_tag;

  always_comb begin
    type_n   = type_e;
    first_n  = first_e;
    second_n = second_e;
    if (!is_tag) begin
      if (d < tw) begin
        type_n = {type_e[23:0], v};
      end else if (d < tw + sw) begin
        first_n = {first_e[23:0], v};
      end else begin
        second_n = {second_e[23:0], v};
      end
    end
  end

  assign last    = (pos_inc == len);
  assign err     = pred_q && (row_tag_n != UP_TAG);
  assign obj_sum = {1'b0, first_obj_q} + {1'b0, row_count_e};
  assign push    = accept && !(cfg_we && cfg_hit) && (len != '0) && last;

  // entry assembly
  always_comb begin
    result.object_number = obj_sum[24] ? OBJ_MAX : obj_sum[23:0];
    result.filter_error  = err;
    if (err) begin
      result.entry_kind = KIND_FREE;
      result.value_a    = '0;
      result.value_b    = '0;
    end else begin
      result.entry_kind = (type_n <= KIND_MAX_VAL) ? type_n[1:0] : KIND_UNKNOWN;
      result.value_a    = first_n;
      result.value_b    = second_n;
    end
  end

  // configuration and row state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_w_q     <= TYPE_WIDTH_RST;
      second_w_q   <= SECOND_WIDTH_RST;
      third_w_q    <= THIRD_WIDTH_RST;
      pred_q       <= PREDICTOR_RST;
      first_obj_q  <= FIRST_OBJECT_RST;
      prev_valid_q <= 1'b0;
      pos_q        <= '0;
      row_tag_q    <= '0;
      type_acc_q   <= '0;
      first_acc_q  <= '0;
      second_acc_q <= '0;
      row_count_q  <= '0;
    end else if (cfg_we && cfg_hit) begin
      case (cfg_index_i)
        CFG_TYPE_WIDTH:   type_w_q    <= cfg_data_i[FieldWW-1:0];
        CFG_SECOND_WIDTH: second_w_q  <= cfg_data_i[FieldWW-1:0];
        CFG_THIRD_WIDTH:  third_w_q   <= cfg_data_i[FieldWW-1:0];
        CFG_PREDICTOR_ON: pred_q      <= cfg_data_i[0];
        CFG_FIRST_OBJECT: first_obj_q <= cfg_data_i[23:0];
        default:          ;
      endcase
      prev_valid_q <= 1'b0;
      pos_q        <= '0;
      row_tag_q    <= '0;
      type_acc_q   <= '0;
      first_acc_q  <= '0;
      second_acc_q <= '0;
    end else if (accept) begin
      if (len == '0) begin
        // empty row: only a stream start has an effect
        prev_valid_q <= prev_valid_e;
        pos_q        <= pos_e;
        row_tag_q    <= row_tag_e;
        type_acc_q   <= type_e;
        first_acc_q  <= first_e;
        second_acc_q <= second_e;
        row_count_q  <= row_count_e;
      end else if (last) begin
        prev_valid_q <= pred_q && !err;
        pos_q        <= '0;
        row_tag_q    <= '0;
        type_acc_q   <= '0;
        first_acc_q  <= '0;
        second_acc_q <= '0;
        row_count_q  <= (row_count_e == OBJ_MAX) ? OBJ_MAX : row_count_e + 24'd1;
      end else begin
        prev_valid_q <= prev_valid_e;
        pos_q        <= pos_inc;
        row_tag_q    <= row_tag_n;
        type_acc_q   <= type_n;
        first_acc_q  <= first_n;
        second_acc_q <= second_n;
        row_count_q  <= row_count_e;
      end
    end
  end

  // previous decoded row bytes
  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_q[idx] <= v;
    end
  end

  xsrd_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (result),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTH
  // row position stays inside the current row
  a_pos_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < len || pos_q == '0)
    else $error("row position beyond row length");

  // a finished row leaves out_valid_o high next cycle
  a_row_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("finished row produced no entry");

  // filter errors carry cleared fields
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.filter_error |->
      out_item_o.entry_kind == KIND_FREE && out_item_o.value_a == '0 &&
      out_item_o.value_b == '0)
    else $error("filter error entry has nonzero fields");

  // without prediction the previous row is never used
  a_no_pred_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pred_q |-> !prev_valid_q)
    else $error("previous row valid with predictor off");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream bench for the cross-reference stream row decoder: feeds rows of
// stream bytes under several width and predictor settings, keeps its own
// row decoder in step with the accepted bytes and compares each emitted
// entry, field by field, with the oldest decoded entry still owed.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xsrd_pkg::*;

  localparam int unsigned MAX_FIELD   = 4;
  localparam int unsigned PREV_DEPTH  = 3 * MAX_FIELD;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned PHASE_ITEMS = 125;

  // Block ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;

  // Stimulus and idling control
  in_item_t    byte_q[$];
  out_item_t   decoded_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned err_count     = 0;

  // Decoder copy: registers
  logic [2:0]  w_type    = TYPE_WIDTH_RST;
  logic [2:0]  w_second  = SECOND_WIDTH_RST;
  logic [2:0]  w_third   = THIRD_WIDTH_RST;
  logic        pred_on   = PREDICTOR_RST;
  logic [23:0] first_obj = FIRST_OBJECT_RST;

  // Decoder copy: row state
  logic [7:0]  prev_row [PREV_DEPTH];
  bit          prev_ok   = 1'b0;
  int unsigned row_pos   = 0;
  logic [7:0]  tag_byte  = '0;
  logic [31:0] acc_type  = '0;
  logic [31:0] acc_a     = '0;
  logic [31:0] acc_b     = '0;
  logic [23:0] row_total = '0;

  xref_stream_row_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial forever #1 clk_i = ~clk_i;

  function automatic int unsigned clampw(logic [2:0] w);
    return (w > MAX_FIELD) ? MAX_FIELD : int'(w);
  endfunction

  task automatic restart_row();
    row_pos  = 0;
    tag_byte = '0;
    acc_type = '0;
    acc_a    = '0;
    acc_b    = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // Advance the decoder copy by one accepted stream byte
  task automatic decode_byte(input in_item_t it);
    int unsigned len;
    int unsigned pos;
    int unsigned d;
    int unsigned tw;
    int unsigned sw;
    logic [7:0]  v;
    logic [24:0] sum;
    bit          err;
    out_item_t   e;
    tw = clampw(w_type);
    sw = clampw(w_second);
    len = int'(pred_on) + tw + sw + clampw(w_third);
    if (it.stream_start) begin
      restart_row();
      row_total = '0;
      prev_ok   = 1'b0;
    end
    if (len == 0) return;
    pos = row_pos;
    if (pos >= len) pos = 0;
    if (pred_on && pos == 0) begin
      tag_byte = it.data_byte;
    end else begin
      d = pos - int'(pred_on);
      v = it.data_byte;
      if (pred_on && d < PREV_DEPTH) begin
        if (prev_ok) v = v + prev_row[d];
        prev_row[d] = v;
      end
      if (d < tw) acc_type = {acc_type[23:0], v};
      else if (d < tw + sw) acc_a = {acc_a[23:0], v};
      else acc_b = {acc_b[23:0], v};
    end
    pos++;
    if (pos < len) begin
      row_pos = pos;
      return;
    end
    // last byte of the row: build the entry
    err = pred_on && (tag_byte != UP_TAG);
    sum = {1'b0, first_obj} + {1'b0, row_total};
    e.object_number = (sum > {1'b0, OBJ_MAX}) ? OBJ_MAX : sum[23:0];
    if (err) begin
      e.entry_kind   = KIND_FREE;
      e.value_a      = '0;
      e.value_b      = '0;
      e.filter_error = 1'b1;
    end else begin
      e.entry_kind   = (acc_type <= KIND_MAX_VAL) ? acc_type[1:0] : KIND_UNKNOWN;
      e.value_a      = acc_a;
      e.value_b      = acc_b;
      e.filter_error = 1'b0;
    end
    decoded_q = {decoded_q, e};
    if (row_total < OBJ_MAX) row_total++;
    prev_ok = pred_on && !err;
    restart_row();
  endtask

  // Register write; the decoder copy follows at the handshake edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TYPE_WIDTH:   w_type    = data[2:0];
      CFG_SECOND_WIDTH: w_second  = data[2:0];
      CFG_THIRD_WIDTH:  w_third   = data[2:0];
      CFG_PREDICTOR_ON: pred_on   = data[0];
      CFG_FIRST_OBJECT: first_obj = data;
      default: return;
    endcase
    restart_row();
    prev_ok = 1'b0;
  endtask

  // Sender held back until nothing is owed, then a latency pause
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    in_item_t it;
    it.data_byte    = b;
    it.stream_start = start;
    byte_q = {byte_q, it};
  endtask

  // One phase: write all registers, pick an idling mode, queue rows
  task automatic run_phase(input logic [2:0] tw, input logic [2:0] sw, input logic [2:0] hw,
                           input logic pr, input logic [23:0] fo, input int unsigned mode);
    logic [CfgDataW-1:0] d;
    int unsigned len;
    int unsigned nb;
    int unsigned cnt;
    bit          restart;
    bit          broken;
    in_item_t    it;
    wait_drained();
    d = CfgDataW'($urandom()); d[2:0] = tw; write_reg(CFG_TYPE_WIDTH, d);
    d = CfgDataW'($urandom()); d[2:0] = sw; write_reg(CFG_SECOND_WIDTH, d);
    d = CfgDataW'($urandom()); d[2:0] = hw; write_reg(CFG_THIRD_WIDTH, d);
    d = CfgDataW'($urandom()); d[0] = pr;   write_reg(CFG_PREDICTOR_ON, d);
    write_reg(CFG_FIRST_OBJECT, fo);
    // an index past the register list changes nothing
    if ($urandom_range(1) == 1)
      write_reg(CFG_FIRST_OBJECT + 3'($urandom_range(3, 1)), CfgDataW'($urandom()));
    cfg_valid <= 1'b0;
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 53; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 53; end
      default: begin send_idle_pct = 13; stall_pct = 13; end
    endcase
    len = int'(pr) + clampw(tw) + clampw(sw) + clampw(hw);
    if (len == 0) begin
      // empty rows: every byte is dropped
      repeat (24) push_byte(8'($urandom()), 1'($urandom_range(1)));
      return;
    end
    cnt = 0;
    restart = 1'($urandom_range(1));
    while (cnt < PHASE_ITEMS) begin
      broken = (len > 1) && ($urandom_range(99) < 5);
      nb = broken ? $urandom_range(len - 1, 1) : len;
      for (int unsigned i = 0; i < nb; i++) begin
        it.stream_start = (i == 0 && restart) || ($urandom_range(199) == 0);
        if (pr && i == 0) begin
          it.data_byte = ($urandom_range(9) == 0) ? 8'($urandom()) : UP_TAG;
        end else begin
          case ($urandom_range(3))
            0: it.data_byte = 8'h00;
            1: it.data_byte = 8'hFF;
            2: it.data_byte = 8'($urandom_range(3));
            default: it.data_byte = 8'($urandom());
          endcase
        end
        byte_q = {byte_q, it};
      end
      cnt += nb;
      restart = broken || ($urandom_range(99) < 4);
    end
  endtask

  // Input driver: takes the next queued byte once the current one is taken
  always @(posedge clk_i) begin
    bit fire;
    fire = in_valid && !in_stall_o;
    if (fire) decode_byte(in_item);
    if (!in_valid || fire) begin
      if (rst_ni && byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Entry monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("entry with none owed, object_number", 32'(out_item_o.object_number), '0);
      end else begin
        want = decoded_q.pop_front();
        if (out_item_o.object_number !== want.object_number)
          report_mismatch("object_number", 32'(out_item_o.object_number),
                          32'(want.object_number));
        if (out_item_o.entry_kind !== want.entry_kind)
          report_mismatch("entry_kind", 32'(out_item_o.entry_kind), 32'(want.entry_kind));
        if (out_item_o.value_a !== want.value_a)
          report_mismatch("value_a", out_item_o.value_a, want.value_a);
        if (out_item_o.value_b !== want.value_b)
          report_mismatch("value_b", out_item_o.value_b, want.value_b);
        if (out_item_o.filter_error !== want.filter_error)
          report_mismatch("filter_error", 32'(out_item_o.filter_error),
                          32'(want.filter_error));
      end
    end
  end

  // Run limit
  initial begin
    #400000;
    $display("xref_stream_row_decoder test failed");
    $finish;
  end

  // Sequence: reset, directed rows at reset settings, then setting phases
  initial begin
    logic [23:0] fo;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first row raw: unknown type, all-ones offset
    push_byte(UP_TAG, 1'b1);
    push_byte(8'hFF, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b0);
    repeat (2) push_byte(8'h00, 1'b0);
    // Up row: type wraps to 2, offset wraps to zero
    push_byte(UP_TAG, 1'b0);
    push_byte(8'h03, 1'b0);
    repeat (4) push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    // bad tag: flagged, next row starts over
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h9A, 1'b0);
    push_byte(8'hBC, 1'b0);
    push_byte(8'hDE, 1'b0);

    run_phase(3'd1, 3'd4, 3'd2, 1'b1, 24'd0, 0);
    run_phase(3'd4, 3'd4, 3'd4, 1'b1, OBJ_MAX - 24'd20, 1);
    run_phase(3'd0, 3'd0, 3'd0, 1'b1, OBJ_MAX - 24'd3, 2);
    run_phase(3'd0, 3'd0, 3'd0, 1'b0, 24'($urandom()), 3);
    run_phase(3'd7, 3'd5, 3'd6, 1'b1, 24'($urandom()), 0);
    run_phase(3'd0, 3'd2, 3'd1, 1'b0, 24'($urandom()), 1);
    run_phase(3'd4, 3'd4, 3'd4, 1'b0, OBJ_MAX, 2);
    run_phase(3'd2, 3'd1, 3'd3, 1'b1, 24'($urandom()), 3);
    for (int unsigned p = 0; p < 5; p++) begin
      case ($urandom_range(2))
        0: fo = '0;
        1: fo = OBJ_MAX - 24'($urandom_range(50));
        default: fo = 24'($urandom());
      endcase
      run_phase(3'($urandom()), 3'($urandom()), 3'($urandom()), 1'($urandom()), fo, p);
    end

    wait_drained();
    if (err_count == 0) begin
      $display("xref_stream_row_decoder test passed");
    end else begin
      $display("xref_stream_row_decoder test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/xsrd_pkg.sv
hdl/xsrd_out_skid.sv
hdl/xref_stream_row_decoder.sv
bench/tb_top.sv
